[design/gtss_pkg.sv]
// Package for the generation-tagged slot store.
// Holds the operation and status codes, field widths and the request structs
// shared by the controller and the two storage modules. No dependencies.
package gtss_pkg;

   localparam int GEN_W     = 32;
   localparam int BYTE_W    = 8;
   localparam int SLOT_F_W  = 8;
   localparam int IDX_W_MAX = 8;
   localparam int CNT_W     = 8;
   // Three pools of at most 256 slots each need ten row bits.
   localparam int ROW_W_MAX = 10;

   typedef enum logic [1:0] {
      OP_CLAIM   = 2'd0,
      OP_WRITE   = 2'd1,
      OP_READ    = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_DENIED  = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   localparam logic [1:0] KIND_SECRET  = 2'd0;
   localparam logic [1:0] KIND_MESSAGE = 2'd1;
   localparam logic [1:0] KIND_TOKEN   = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   typedef struct packed {
      logic             occupied;
      logic [GEN_W-1:0] generation;
   } slot_meta_type;

   typedef struct packed {
      logic                 we;
      logic [ROW_W_MAX-1:0] row;
      slot_meta_type        wdata;
   } meta_req_type;

   typedef struct packed {
      logic                 we;
      logic [ROW_W_MAX-1:0] row;
      logic [IDX_W_MAX-1:0] idx;
      logic [BYTE_W-1:0]    wdata;
   } byte_req_type;

endpackage

[design/gtss_if.sv]
// Valid/ready channel interfaces for the request and response sides.
// Depends on gtss_pkg for the field widths.
interface gtss_req_if import gtss_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [1:0]          kind;
   logic [SLOT_F_W-1:0] lease_slot;
   logic [GEN_W-1:0]    lease_generation;
   logic [7:0]          byte_index;
   logic [BYTE_W-1:0]   byte_value;

   modport source (output valid, op, kind, lease_slot, lease_generation, byte_index,
                   byte_value, input ready);
   modport sink (input valid, op, kind, lease_slot, lease_generation, byte_index,
                 byte_value, output ready);
endinterface

interface gtss_rsp_if import gtss_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [SLOT_F_W-1:0] granted_slot;
   logic [GEN_W-1:0]    granted_generation;
   logic [BYTE_W-1:0]   read_byte;

   modport source (output valid, status, granted_slot, granted_generation, read_byte,
                   input ready);
   modport sink (input valid, status, granted_slot, granted_generation, read_byte,
                 output ready);
endinterface

[design/generation_tagged_slot_store_top.sv]
// A claim searches the pool for a free slot and then wipes that slot's bytes; a
// release checks the lease, frees the slot and wipes its bytes.
// One request at a time: the slot search and the byte wipe step the shared counter.
// A finished result waits in an output register while the next request is taken.
// Reset is synchronous, active high; a clearing pass then zeroes the slot table,
// and no request is taken until it ends.
module generation_tagged_slot_store_top import gtss_pkg::*; #(
   parameter int SLOTS         = 8,
   parameter int SECRET_BYTES  = 32,
   parameter int MESSAGE_BYTES = 64,
   parameter int TOKEN_BYTES   = 64
) (
   input  logic       clock,
   input  logic       reset,
   gtss_req_if.sink   req_chan,
   gtss_rsp_if.source rsp_chan
);

   // Requests between the sequencer and the two storage modules.
   meta_req_type      meta_req;
   slot_meta_type     meta_rdata;
   logic              tbl_ready;
   byte_req_type      byte_req;
   logic [BYTE_W-1:0] byte_rdata;

   // The sequencer owns both channels. It takes one request transfer, works
   // it through the slot table and byte store, and parks the result in its
   // output register until the response transfer completes.
   gtss_ctrl #(
      .SLOTS         (SLOTS),
      .SECRET_BYTES  (SECRET_BYTES),
      .MESSAGE_BYTES (MESSAGE_BYTES),
      .TOKEN_BYTES   (TOKEN_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .meta_req   (meta_req),
      .meta_rdata (meta_rdata),
      .tbl_ready  (tbl_ready),
      .byte_req   (byte_req),
      .byte_rdata (byte_rdata)
   );

   // Occupied flags and generations of all pools, one row per slot.
   gtss_slot_table #(
      .SLOTS (SLOTS)
   ) u_slot_table (
      .clock      (clock),
      .reset      (reset),
      .meta_req   (meta_req),
      .meta_rdata (meta_rdata),
      .tbl_ready  (tbl_ready)
   );

   // Buffer bytes. Every byte a lease can reach is zeroed by its claim, so
   // this memory needs no clearing after reset.
   gtss_byte_store #(
      .SLOTS         (SLOTS),
      .SECRET_BYTES  (SECRET_BYTES),
      .MESSAGE_BYTES (MESSAGE_BYTES),
      .TOKEN_BYTES   (TOKEN_BYTES)
   ) u_byte_store (
      .clock      (clock),
      .byte_req   (byte_req),
      .byte_rdata (byte_rdata)
   );

endmodule

[design/gtss_slot_table.sv]
// Slot table: occupied flag and generation for every slot of every pool.
// Depends on gtss_pkg. Runs a clearing pass over all rows after reset.
module gtss_slot_table import gtss_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  meta_req_type  meta_req,
   output slot_meta_type meta_rdata,
   output logic          tbl_ready
);

   localparam int ROWS  = 3 * SLOTS;
   localparam int ROW_W = $clog2(ROWS);

   slot_meta_type mem [ROWS];

   logic             clr_busy_ff, clr_busy_in;
   logic [ROW_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic             wr_en;
   logic [ROW_W-1:0] wr_row;
   slot_meta_type    wr_data;
   slot_meta_type    rdata_ff;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clr_busy_ff) begin
         if (clr_ptr_ff == ROW_W'(ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_ptr_in = clr_ptr_ff + 1'b1;
         end
      end
   end

   // The clearing pass owns the write port until it is done.
   assign wr_en   = clr_busy_ff | meta_req.we;
   assign wr_row  = clr_busy_ff ? clr_ptr_ff : meta_req.row[ROW_W-1:0];
   assign wr_data = clr_busy_ff ? '0 : meta_req.wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_ptr_ff  <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      rdata_ff <= mem[meta_req.row[ROW_W-1:0]];
   end

   assign meta_rdata = rdata_ff;
   assign tbl_ready  = ~clr_busy_ff;

endmodule

[design/gtss_byte_store.sv]
// Byte store: the buffer bytes of every slot of every pool, one row per slot.
// Depends on gtss_pkg. Contents are undefined until written.
module gtss_byte_store import gtss_pkg::*; #(
   parameter int SLOTS         = 8,
   parameter int SECRET_BYTES  = 32,
   parameter int MESSAGE_BYTES = 64,
   parameter int TOKEN_BYTES   = 64
) (
   input  logic              clock,
   input  byte_req_type      byte_req,
   output logic [BYTE_W-1:0] byte_rdata
);

   localparam int ROWS  = 3 * SLOTS;
   localparam int ROW_W = $clog2(ROWS);
   localparam int BUF0  = (SECRET_BYTES > MESSAGE_BYTES) ? SECRET_BYTES : MESSAGE_BYTES;
   localparam int BUF   = (BUF0 > TOKEN_BYTES) ? BUF0 : TOKEN_BYTES;
   localparam int IDX_W = (BUF > 1) ? $clog2(BUF) : 1;
   localparam int DEPTH = ROWS << IDX_W;

   logic [BYTE_W-1:0]      mem [DEPTH];
   logic [ROW_W+IDX_W-1:0] addr;
   logic [BYTE_W-1:0]      rdata_ff;

   assign addr = {byte_req.row[ROW_W-1:0], byte_req.idx[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (byte_req.we) begin
         mem[addr] <= byte_req.wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign byte_rdata = rdata_ff;

endmodule

[design/gtss_ctrl.sv]
// Sequencer of the slot store: lease checks, slot search and byte wipes;
// the search and the wipes share one step counter and compare. Depends on gtss_pkg
// and the channel interfaces in gtss_if.sv.
module gtss_ctrl import gtss_pkg::*; #(
   parameter int SLOTS         = 8,
   parameter int SECRET_BYTES  = 32,
   parameter int MESSAGE_BYTES = 64,
   parameter int TOKEN_BYTES   = 64
) (
   input  logic              clock,
   input  logic              reset,
   gtss_req_if.sink          req_chan,
   gtss_rsp_if.source        rsp_chan,
   output meta_req_type      meta_req,
   input  slot_meta_type     meta_rdata,
   input  logic              tbl_ready,
   output byte_req_type      byte_req,
   input  logic [BYTE_W-1:0] byte_rdata
);

   localparam int ROWS = 3 * SLOTS;
   localparam logic [ROW_W_MAX-1:0] MSG_BASE  = ROW_W_MAX'(SLOTS);
   localparam logic [ROW_W_MAX-1:0] TOK_BASE  = ROW_W_MAX'(2 * SLOTS);
   localparam logic [8:0]           SLOT_LIM  = 9'(SLOTS);
   localparam logic [CNT_W-1:0]     LAST_SLOT = CNT_W'(SLOTS - 1);
   localparam logic [8:0]           SEC_SIZE  = 9'(SECRET_BYTES);
   localparam logic [8:0]           MSG_SIZE  = 9'(MESSAGE_BYTES);
   localparam logic [8:0]           TOK_SIZE  = 9'(TOKEN_BYTES);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DISPATCH  = 8'b0000_0010,
      S_SCAN_RD   = 8'b0000_0100,
      S_SCAN_CHK  = 8'b0000_1000,
      S_LEASE_CHK = 8'b0001_0000,
      S_READ_WAIT = 8'b0010_0000,
      S_WIPE      = 8'b0100_0000,
      S_FINISH    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   op_type              op_ff, op_in;
   logic [1:0]          kind_ff, kind_in;
   logic [SLOT_F_W-1:0] slot_ff, slot_in;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic [7:0]          idx_ff, idx_in;
   logic [BYTE_W-1:0]   val_ff, val_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ROW_W_MAX-1:0] row_ff, row_in;

   status_type          res_status_ff, res_status_in;
   logic [SLOT_F_W-1:0] res_slot_ff, res_slot_in;
   logic [GEN_W-1:0]    res_gen_ff, res_gen_in;
   logic [BYTE_W-1:0]   res_rd_ff, res_rd_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [SLOT_F_W-1:0] rsp_slot_ff;
   logic [GEN_W-1:0]    rsp_gen_ff;
   logic [BYTE_W-1:0]   rsp_rd_ff;

   logic                 req_fire;
   logic                 load;
   logic [ROW_W_MAX-1:0] base_row;
   logic [8:0]           pool_size;
   logic [CNT_W-1:0]     size_m1;
   logic                 slot_in_range;
   logic                 lease_fields_ok;
   logic [ROW_W_MAX-1:0] lease_row;
   logic [ROW_W_MAX-1:0] scan_row;
   logic                 lease_match;
   logic                 cnt_at_limit;
   logic [CNT_W-1:0]     cnt_limit;
   logic [GEN_W-1:0]     gen_inc;
   logic [GEN_W-1:0]     gen_next;

   always_comb begin
      unique case (kind_ff)
         KIND_SECRET:  base_row = '0;
         KIND_MESSAGE: base_row = MSG_BASE;
         default:      base_row = TOK_BASE;
      endcase
   end

   always_comb begin
      unique case (kind_ff)
         KIND_SECRET:  pool_size = SEC_SIZE;
         KIND_MESSAGE: pool_size = MSG_SIZE;
         KIND_INVALID: pool_size = 9'd0;
         default:      pool_size = TOK_SIZE;
      endcase
   end

   assign size_m1         = CNT_W'(pool_size - 9'd1);
   assign slot_in_range   = {1'b0, slot_ff} < SLOT_LIM;
   assign lease_fields_ok = (kind_ff != KIND_INVALID) && slot_in_range && (gen_ff != '0);
   assign lease_row       = base_row + ROW_W_MAX'(slot_ff);
   assign scan_row        = base_row + ROW_W_MAX'(cnt_ff);
   assign lease_match     = meta_rdata.occupied && (meta_rdata.generation == gen_ff);

   // Shared step unit: the same counter and compare walk slots during a
   // search and byte positions during a wipe.
   assign cnt_limit    = (state_ff == S_WIPE) ? size_m1 : LAST_SLOT;
   assign cnt_at_limit = (cnt_ff == cnt_limit);

   assign gen_inc  = meta_rdata.generation + 1'b1;
   assign gen_next = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

   assign req_chan.ready = (state_ff == S_IDLE) && tbl_ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign load           = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      kind_in       = kind_ff;
      slot_in       = slot_ff;
      gen_in        = gen_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_gen_in    = res_gen_ff;
      res_rd_in     = res_rd_ff;

      meta_req.we    = 1'b0;
      meta_req.row   = row_ff;
      meta_req.wdata = meta_rdata;
      byte_req.we    = 1'b0;
      byte_req.row   = row_ff;
      byte_req.idx   = idx_ff;
      byte_req.wdata = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = op_type'(req_chan.op);
               kind_in  = req_chan.kind;
               slot_in  = req_chan.lease_slot;
               gen_in   = req_chan.lease_generation;
               idx_in   = req_chan.byte_index;
               val_in   = req_chan.byte_value;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_status_in = STAT_OK;
            res_slot_in   = '0;
            res_gen_in    = '0;
            res_rd_in     = '0;
            cnt_in        = '0;
            unique case (op_ff)
               OP_CLAIM: begin
                  if (kind_ff == KIND_INVALID) begin
                     res_status_in = STAT_INVALID;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               OP_WRITE, OP_READ: begin
                  if (kind_ff == KIND_INVALID || {1'b0, idx_ff} >= pool_size) begin
                     res_status_in = STAT_INVALID;
                     state_in      = S_FINISH;
                  end else if (!lease_fields_ok) begin
                     res_status_in = STAT_DENIED;
                     state_in      = S_FINISH;
                  end else begin
                     meta_req.row = lease_row;
                     row_in       = lease_row;
                     state_in     = S_LEASE_CHK;
                  end
               end
               OP_RELEASE: begin
                  if (!lease_fields_ok) begin
                     res_status_in = STAT_DENIED;
                     state_in      = S_FINISH;
                  end else begin
                     meta_req.row = lease_row;
                     row_in       = lease_row;
                     state_in     = S_LEASE_CHK;
                  end
               end
            endcase
         end
         S_SCAN_RD: begin
            meta_req.row = scan_row;
            row_in       = scan_row;
            state_in     = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (!meta_rdata.occupied) begin
               meta_req.we                  = 1'b1;
               meta_req.wdata.occupied      = 1'b1;
               meta_req.wdata.generation    = gen_next;
               res_slot_in                  = SLOT_F_W'(cnt_ff);
               res_gen_in                   = gen_next;
               cnt_in                       = '0;
               state_in                     = S_WIPE;
            end else if (cnt_at_limit) begin
               res_status_in = STAT_FULL;
               state_in      = S_FINISH;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_LEASE_CHK: begin
            if (!lease_match) begin
               res_status_in = STAT_DENIED;
               state_in      = S_FINISH;
            end else begin
               unique case (op_ff)
                  OP_WRITE: begin
                     byte_req.we = 1'b1;
                     state_in    = S_FINISH;
                  end
                  OP_READ: begin
                     state_in = S_READ_WAIT;
                  end
                  OP_RELEASE: begin
                     meta_req.we             = 1'b1;
                     meta_req.wdata.occupied = 1'b0;
                     cnt_in                  = '0;
                     state_in                = S_WIPE;
                  end
                  OP_CLAIM: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_READ_WAIT: begin
            res_rd_in = byte_rdata;
            state_in  = S_FINISH;
         end
         S_WIPE: begin
            byte_req.we    = 1'b1;
            byte_req.idx   = cnt_ff;
            byte_req.wdata = '0;
            if (cnt_at_limit) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      kind_ff       <= kind_in;
      slot_ff       <= slot_in;
      gen_ff        <= gen_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      cnt_ff        <= cnt_in;
      row_ff        <= row_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_gen_ff    <= res_gen_in;
      res_rd_ff     <= res_rd_in;
      if (load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_gen_ff    <= res_gen_ff;
         rsp_rd_ff     <= res_rd_ff;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.status             = rsp_status_ff;
   assign rsp_chan.granted_slot       = rsp_slot_ff;
   assign rsp_chan.granted_generation = rsp_gen_ff;
   assign rsp_chan.read_byte          = rsp_rd_ff;

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the finish step");

   a_meta_row_range: assert property (@(posedge clock) disable iff (reset)
      meta_req.we |-> (meta_req.row < ROW_W_MAX'(ROWS)))
      else $error("slot table write beyond the last row");

   a_claim_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      (load && res_status_ff == STAT_OK && op_ff == OP_CLAIM) |-> (res_gen_ff != '0))
      else $error("successful claim returned generation zero");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      !tbl_ready |-> !req_chan.ready)
      else $error("request taken during the slot table clearing pass");

   a_wipe_in_pool: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WIPE) |-> (kind_ff != KIND_INVALID && cnt_ff <= size_m1))
      else $error("wipe beyond the pool size");
`endif

endmodule
